// ===== hdl/cdq_pkg.sv =====
// shared types and constants for the circular deque
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FN_POP_FRONT  = 2'd1;
  localparam logic [1:0] FN_PUSH_REAR  = 2'd2;
  localparam logic [1:0] FN_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] pop_value;
    logic [OCC_W-1:0]         occupancy;
  } out_t;

endpackage

// ===== hdl/circular_deque_core.sv =====
// circular deque: four-function double-ended queue over a ram store
// results: pushes and refusals give their result in the cycle after the input beat, a successful
//   pop after the ram read register and then the output register
// throughput: one item a cycle for pushes and refusals while the sink keeps up; a pop
//   blocks input in S_READ, set by the single ram read port and one-item-at-a-time sequencer
// reset: pointers and count clear (deque empty), output invalid; store left as it is
`timescale 1ns / 1ps
module circular_deque_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdq_pkg::out_t out_data_o
);

  localparam logic [cdq_pkg::AW-1:0] LAST = cdq_pkg::AW'(cdq_pkg::DEPTH - 1);
  localparam logic [cdq_pkg::CW-1:0] FULL = cdq_pkg::CW'(cdq_pkg::DEPTH);

  cdq_pkg::state_e              state_q, state_d;
  logic [cdq_pkg::AW-1:0]       front_q, front_d, rear_q, rear_d;
  logic [cdq_pkg::CW-1:0]       cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  cdq_pkg::out_t                out_data_q, out_data_d;
  logic                         accept;
  logic                         we;
  logic [cdq_pkg::AW-1:0]       waddr, raddr;
  logic [cdq_pkg::WORD_W-1:0]   rdata;

  function automatic logic [cdq_pkg::AW-1:0] ptr_inc(input logic [cdq_pkg::AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [cdq_pkg::AW-1:0] ptr_dec(input logic [cdq_pkg::AW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  cdq_ram #(
    .WIDTH (cdq_pkg::WORD_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.push_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == cdq_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          out_data_d.status    = cdq_pkg::ST_DONE;
          out_data_d.pop_value = '0;
          unique case (in_data_i.func) inside
            cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
              out_valid_d = 1'b1;
              if (cnt_q == '0) begin
                // first element always lands in slot zero
                front_d = '0;
                rear_d  = '0;
                we      = 1'b1;
                waddr   = '0;
                cnt_d   = cnt_q + 1'b1;
              end else if (cnt_q == FULL) begin
                out_data_d.status = cdq_pkg::ST_FULL;
              end else if (in_data_i.func == cdq_pkg::FN_PUSH_FRONT) begin
                front_d = ptr_dec(front_q);
                we      = 1'b1;
                waddr   = ptr_dec(front_q);
                cnt_d   = cnt_q + 1'b1;
              end else begin
                rear_d  = ptr_inc(rear_q);
                we      = 1'b1;
                waddr   = ptr_inc(rear_q);
                cnt_d   = cnt_q + 1'b1;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                out_data_d.status = cdq_pkg::ST_EMPTY;
                out_valid_d       = 1'b1;
              end else begin
                // pointers move now, the word arrives from the ram next cycle
                state_d = cdq_pkg::S_READ;
                cnt_d   = cnt_q - 1'b1;
                if (in_data_i.func == cdq_pkg::FN_POP_FRONT) begin
                  raddr   = front_q;
                  front_d = ptr_inc(front_q);
                end else begin
                  raddr  = rear_q;
                  rear_d = ptr_dec(rear_q);
                end
                if (cnt_q == cdq_pkg::CW'(1)) begin
                  front_d = '0;
                  rear_d  = '0;
                end
              end
            end
          endcase
          out_data_d.occupancy = cdq_pkg::OCC_W'(cnt_d);
        end
      end
      cdq_pkg::S_READ: begin
        out_data_d.pop_value = rdata;
        out_valid_d          = 1'b1;
        state_d              = cdq_pkg::S_IDLE;
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// ===== hdl/cdq_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cdq_checker.sv =====
// port-level assertions for the circular deque, bound to the top level
`timescale 1ns / 1ps
module cdq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cdq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cdq_pkg::out_t out_data_o
);

  // an input beat waiting on the block holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // a result beat waiting on the sink holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // full refusal only when the store is at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == cdq_pkg::ST_FULL) |->
      (out_data_o.occupancy == cdq_pkg::OCC_W'(cdq_pkg::DEPTH)))
    else $error("full status with wrong occupancy");

  // empty refusal reports nothing stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == cdq_pkg::ST_EMPTY) |->
      (out_data_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // a refused operation never returns a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != cdq_pkg::ST_DONE) |->
      (out_data_o.pop_value == '0))
    else $error("refused operation returned a word");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for circular_deque_core with a built-in deque predictor
`timescale 1ns / 1ps
module tb_top;
  import cdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // predictor state
  logic signed [WORD_W-1:0] slots [DEPTH];
  logic [AW-1:0] head_idx;
  logic [AW-1:0] tail_idx;
  logic dq_empty;

  out_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int recv_stall_left = 0;

  circular_deque_core DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic int held_count();
    if (dq_empty) return 0;
    return ((int'(tail_idx) + DEPTH - int'(head_idx)) % DEPTH) + 1;
  endfunction

  function automatic void clear_deque();
    dq_empty = 1'b1;
    head_idx = '0;
    tail_idx = '0;
  endfunction

  // applies one operation to the predicted deque and returns the expected beat
  function automatic out_t apply_op(input in_t beat);
    out_t res;
    int occ;
    res = '0;
    res.status = ST_DONE;
    if (beat.func == FN_PUSH_FRONT || beat.func == FN_PUSH_REAR) begin
      if (dq_empty) begin
        // push into empty lands in slot 0 whichever end is named
        head_idx = '0;
        tail_idx = '0;
        slots[0] = beat.push_value;
        dq_empty = 1'b0;
      end else if (held_count() >= DEPTH) begin
        res.status = ST_FULL;
      end else if (beat.func == FN_PUSH_FRONT) begin
        head_idx = step_back(head_idx);
        slots[head_idx] = beat.push_value;
      end else begin
        tail_idx = step_fwd(tail_idx);
        slots[tail_idx] = beat.push_value;
      end
    end else begin
      if (dq_empty) begin
        res.status = ST_EMPTY;
      end else if (beat.func == FN_POP_FRONT) begin
        res.pop_value = slots[head_idx];
        if (head_idx == tail_idx) clear_deque();
        else head_idx = step_fwd(head_idx);
      end else begin
        res.pop_value = slots[tail_idx];
        if (head_idx == tail_idx) clear_deque();
        else tail_idx = step_back(tail_idx);
      end
    end
    occ = held_count();
    res.occupancy = occ[OCC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // receive side: random stall bursts
  always @(negedge clk) begin
    if (recv_stall_left > 0) begin
      out_ready = 1'b0;
      recv_stall_left--;
    end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      recv_stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, status", out_data.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.pop_value !== want.pop_value)
          report_mismatch("pop_value", out_data.pop_value, want.pop_value);
        if (out_data.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_data.occupancy, want.occupancy);
      end
    end
  end

  task automatic send_op(input logic [1:0] fn, input logic signed [WORD_W-1:0] val);
    in_t beat;
    beat.func = fn;
    beat.push_value = val;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = beat;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_op(beat));
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b0, {(WORD_W-1){1'b1}}};
      3: return {1'b1, {(WORD_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
    return $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
  endfunction

  // empty pops, single-element round trips, fill to full, refused pushes, drain
  task automatic test_directed();
    send_op(FN_POP_FRONT, 32'sh1234_5678);
    send_op(FN_POP_REAR, '1);
    send_op(FN_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(FN_POP_REAR, '0);
    send_op(FN_PUSH_REAR, 32'sh8000_0000);
    send_op(FN_POP_FRONT, 32'sh5555_5555);
    send_op(FN_PUSH_REAR, '0);
    send_op(FN_PUSH_FRONT, '1);
    send_op(FN_PUSH_REAR, 32'sh5555_5555);
    send_op(FN_PUSH_FRONT, 32'shaaaa_aaaa);
    send_op(FN_PUSH_REAR, 32'sh7fff_ffff);
    send_op(FN_PUSH_FRONT, 32'sh8000_0000);
    send_op(FN_PUSH_FRONT, 32'sh0000_0001);
    send_op(FN_PUSH_REAR, 32'sh8000_0001);
    send_op(FN_PUSH_FRONT, 32'sh0bad_cafe);
    send_op(FN_PUSH_REAR, 32'shdead_beef);
    send_op(FN_POP_FRONT, '1);
    send_op(FN_POP_REAR, '1);
    send_op(FN_POP_FRONT, '0);
    send_op(FN_POP_REAR, '0);
    send_op(FN_POP_FRONT, '1);
    send_op(FN_POP_REAR, '0);
    send_op(FN_POP_FRONT, '0);
    send_op(FN_POP_REAR, '1);
    send_op(FN_POP_FRONT, '0);
  endtask

  // biased random walk so occupancy sweeps between empty and full
  task automatic test_random_walk(input int n_items);
    int push_pct;
    int run_left;
    push_pct = 50;
    run_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 50);
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 75;
        endcase
      end
      run_left--;
      send_op(pick_op(push_pct), rand_word());
    end
  endtask

  // push one end and pop the other so both pointers walk around the ring
  task automatic test_ring_rotation(input int n_pairs);
    int level;
    level = $urandom_range(1, DEPTH - 1);
    for (int i = 0; i < level; i++) send_op(FN_PUSH_REAR, rand_word());
    for (int i = 0; i < n_pairs; i++) begin
      if ($urandom_range(0, 1)) begin
        send_op(FN_PUSH_REAR, rand_word());
        send_op(FN_POP_FRONT, rand_word());
      end else begin
        send_op(FN_PUSH_FRONT, rand_word());
        send_op(FN_POP_REAR, rand_word());
      end
    end
  endtask

  // final stretch: full rate on both sides
  task automatic test_back_to_back(input int n_items);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    for (int i = 0; i < n_items; i++) send_op(pick_op($urandom_range(30, 70)), rand_word());
  endtask

  initial begin
    clear_deque();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_walk(1000);
    test_ring_rotation(150);
    test_back_to_back(350);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
